/* src/lmks_pkg.sv */
// ============================================================================
// lmks_pkg - learned matrix keypad scanner shared definitions
// Types, sizes and helper functions used by the scanner core, the pair
// table and the top level.
// ============================================================================
package lmks_pkg;

    localparam int MAX_PINS  = 7;
    localparam int KEY_COUNT = 12;

    localparam int PIN_W   = 3;   // pin index width
    localparam int KEY_W   = 4;   // layout position width
    localparam int LEVEL_W = 7;   // sampled pin levels
    localparam int CHAR_W  = 7;   // ASCII character
    localparam int ENTRY_W = 7;   // valid + read pin + drive pin

    localparam int ENTRY_VALID_BIT = 6;

    localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(KEY_COUNT - 1);
    localparam logic [PIN_W-1:0] PIN_MIN  = PIN_W'(2);
    localparam logic [PIN_W-1:0] PIN_MAX  = PIN_W'(MAX_PINS);

    typedef enum logic [1:0] {
        PH_SCAN  = 2'd0,
        PH_SWEEP = 2'd1,
        PH_LWAIT = 2'd2,
        PH_SWAIT = 2'd3
    } t_phase;

    typedef logic [ENTRY_W-1:0] t_entry;

    typedef struct packed {
        logic             wr_en;
        logic [KEY_W-1:0] wr_addr;
        t_entry           wr_data;
        logic [KEY_W-1:0] rd_addr;
    } t_tbl_req;

    typedef struct packed {
        logic [PIN_W-1:0]  drive_line;
        logic              drive_enable;
        logic              key_valid;
        logic [KEY_W-1:0]  key_number;
        logic [CHAR_W-1:0] key_char;
        logic              learning;
        logic [KEY_W-1:0]  prompt_key;
    } t_result;

    // Pin count clamped into the usable range
    function automatic logic [PIN_W-1:0] eff_count(input logic [PIN_W-1:0] pin_count);
        logic [PIN_W-1:0] c;
        c = pin_count;
        if (c < PIN_MIN) c = PIN_MIN;
        if (c > PIN_MAX) c = PIN_MAX;
        return c;
    endfunction

    // Pin at or beyond index 7 never reads low
    function automatic logic reads_low(input logic [LEVEL_W-1:0] lv,
                                       input logic [PIN_W-1:0] idx);
        logic [7:0] ext;
        ext = {1'b1, lv};
        return !ext[idx];
    endfunction

    function automatic logic entry_ok(input t_entry e, input logic [PIN_W-1:0] pc);
        return e[ENTRY_VALID_BIT] && (e[5:3] < pc) && (e[2:0] < pc);
    endfunction

    // Layout order of a 3x4 phone keypad
    function automatic logic [CHAR_W-1:0] key_char_of(input logic [KEY_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            4'd0:    ch = 7'h31;  // '1'
            4'd1:    ch = 7'h32;  // '2'
            4'd2:    ch = 7'h33;  // '3'
            4'd3:    ch = 7'h34;  // '4'
            4'd4:    ch = 7'h35;  // '5'
            4'd5:    ch = 7'h36;  // '6'
            4'd6:    ch = 7'h37;  // '7'
            4'd7:    ch = 7'h38;  // '8'
            4'd8:    ch = 7'h39;  // '9'
            4'd9:    ch = 7'h2A;  // '*'
            4'd10:   ch = 7'h30;  // '0'
            4'd11:   ch = 7'h23;  // '#'
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

/* src/lmks_pair_table.sv */
// ============================================================================
// lmks_pair_table - learned read/drive pair per key position
// Twelve entries with valid flags cleared at reset, one write port, one
// read port with write forwarding, and a copy of the entry at key_pos.
// ============================================================================
module lmks_pair_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  lmks_pkg::t_tbl_req   i_req,
    output lmks_pkg::t_entry     o_rd_entry,   // entry at rd_addr, this cycle
    output lmks_pkg::t_entry     o_cur_entry   // entry at the current key_pos
);
    import lmks_pkg::*;

    t_entry               r_mem [KEY_COUNT];
    logic [KEY_COUNT-1:0] r_valid;
    t_entry               r_cur_entry;
    t_entry               n_rd_entry;

    always_comb begin
        n_rd_entry = '0;
        if (i_req.wr_en && (i_req.wr_addr == i_req.rd_addr)) begin
            n_rd_entry = i_req.wr_data;
        end else if ((i_req.rd_addr < KEY_W'(KEY_COUNT)) && r_valid[i_req.rd_addr]) begin
            n_rd_entry = r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_req.wr_en && (i_req.wr_addr < KEY_W'(KEY_COUNT))) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cur_entry <= '0;
        end else if (i_step) begin
            if (i_req.wr_en && (i_req.wr_addr < KEY_W'(KEY_COUNT))) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            r_cur_entry <= n_rd_entry;
        end
    end

    assign o_rd_entry  = n_rd_entry;
    assign o_cur_entry = r_cur_entry;

endmodule

/* src/lmks_core.sv */
// ============================================================================
// lmks_core - scan / learn sequencer
// Phase and position registers with the combinational step logic that turns
// one item into the next state and one result.
// ============================================================================
module lmks_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_op,
    input  logic [lmks_pkg::LEVEL_W-1:0]      i_pin_levels,
    input  logic [lmks_pkg::PIN_W-1:0]        i_pin_count,
    input  lmks_pkg::t_entry                  i_cur_entry,
    input  lmks_pkg::t_entry                  i_rd_entry,
    output lmks_pkg::t_tbl_req                o_req,
    output lmks_pkg::t_result                 o_result
);
    import lmks_pkg::*;

    t_phase           r_phase,      n_phase;
    logic [KEY_W-1:0] r_key_pos,    n_key_pos;
    logic [PIN_W-1:0] r_sweep_pos,  n_sweep_pos;
    logic [PIN_W-1:0] r_held_read,  n_held_read;
    logic [PIN_W-1:0] r_held_drive, n_held_drive;

    logic [PIN_W-1:0] pc;
    logic             found;
    logic [PIN_W-1:0] found_pin;
    t_result          step_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SCAN;
            r_key_pos    <= '0;
            r_sweep_pos  <= '0;
            r_held_read  <= '0;
            r_held_drive <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_key_pos    <= n_key_pos;
            r_sweep_pos  <= n_sweep_pos;
            r_held_read  <= n_held_read;
            r_held_drive <= n_held_drive;
        end
    end

    assign pc = eff_count(i_pin_count);

    // lowest pressed pin other than the swept one
    always_comb begin
        found     = 1'b0;
        found_pin = '0;
        if (r_sweep_pos < pc) begin
            for (int i = 0; i < LEVEL_W; i++) begin
                if (!found && (PIN_W'(i) < pc) && (PIN_W'(i) != r_sweep_pos)
                    && !i_pin_levels[i]) begin
                    found     = 1'b1;
                    found_pin = PIN_W'(i);
                end
            end
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_key_pos    = r_key_pos;
        n_sweep_pos  = r_sweep_pos;
        n_held_read  = r_held_read;
        n_held_drive = r_held_drive;
        o_req        = '0;
        step_res     = '0;

        if (i_op) begin
            n_phase     = PH_SWEEP;
            n_key_pos   = '0;
            n_sweep_pos = '0;
        end else begin
            case (r_phase)
                PH_SCAN: begin
                    if (entry_ok(i_cur_entry, pc) && reads_low(i_pin_levels, i_cur_entry[5:3]))
                    begin
                        n_held_read  = i_cur_entry[5:3];
                        n_held_drive = i_cur_entry[2:0];
                        n_phase      = PH_SWAIT;
                    end else begin
                        n_key_pos = (r_key_pos >= KEY_LAST) ? '0 : r_key_pos + 1'b1;
                    end
                end
                PH_SWAIT: begin
                    if (!reads_low(i_pin_levels, r_held_read)) begin
                        step_res.key_valid  = 1'b1;
                        step_res.key_number = r_key_pos;
                        step_res.key_char   = key_char_of(r_key_pos);
                        n_key_pos           = '0;
                        n_phase             = PH_SCAN;
                    end
                end
                PH_SWEEP: begin
                    if (found) begin
                        o_req.wr_en   = 1'b1;
                        o_req.wr_addr = r_key_pos;
                        o_req.wr_data = {1'b1, found_pin, r_sweep_pos};
                        n_held_read   = found_pin;
                        n_held_drive  = r_sweep_pos;
                        n_phase       = PH_LWAIT;
                    end else if (({1'b0, r_sweep_pos} + 1'b1) >= {1'b0, pc}) begin
                        n_sweep_pos = '0;
                    end else begin
                        n_sweep_pos = r_sweep_pos + 1'b1;
                    end
                end
                PH_LWAIT: begin
                    if (!reads_low(i_pin_levels, r_held_read)) begin
                        if (r_key_pos >= KEY_LAST) begin
                            n_key_pos = '0;
                            n_phase   = PH_SCAN;
                        end else begin
                            n_key_pos   = r_key_pos + 1'b1;
                            n_sweep_pos = '0;
                            n_phase     = PH_SWEEP;
                        end
                    end
                end
                default: n_phase = PH_SCAN;
            endcase
        end

        // entry for the position scanned next comes straight from the table
        o_req.rd_addr = n_key_pos;
    end

    // drive line and prompt for the next tick
    always_comb begin
        o_result = step_res;

        case (n_phase)
            PH_SCAN: begin
                if (entry_ok(i_rd_entry, pc)) begin
                    o_result.drive_line   = i_rd_entry[2:0];
                    o_result.drive_enable = 1'b1;
                end
            end
            PH_SWEEP: begin
                if (n_sweep_pos < pc) begin
                    o_result.drive_line   = n_sweep_pos;
                    o_result.drive_enable = 1'b1;
                end
            end
            default: begin
                if (n_held_drive < pc) begin
                    o_result.drive_line   = n_held_drive;
                    o_result.drive_enable = 1'b1;
                end
            end
        endcase

        if ((n_phase == PH_SWEEP) || (n_phase == PH_LWAIT)) begin
            o_result.learning   = 1'b1;
            o_result.prompt_key = n_key_pos;
        end
    end

endmodule

/* src/learned_matrix_keypad_scanner.sv */
// ============================================================================
// learned_matrix_keypad_scanner - keypad scanner with learned pin mapping
// Learns which read/drive pin pair belongs to each of twelve keys, then
// scans those pairs one per tick and reports each key on release.
// ============================================================================
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | i_valid / o_stall  | i_op, i_pin_levels
//  out      | o_valid / i_stall  | o_drive_line, o_drive_enable, o_key_valid,
//           |                    | o_key_number, o_key_char, o_learning,
//           |                    | o_prompt_key
//  config   | APB, pready tied 1 | pin_count at every byte address
//
//  One item per clock while i_stall is low; each item passes the input
//  register, then the step logic and a table read into the result register.
//  The step through the phase logic and the 12-entry pair table read sets
//  the cycle time.
//  Synchronous active-low reset: scan phase, position zero, all pairs
//  invalid, pin_count 7. No clearing pass.
//  A stalled result holds; the input register still fills behind it, and
//  o_stall rises only when both stages are full.
// ============================================================================
module learned_matrix_keypad_scanner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_op,
    input  logic [lmks_pkg::LEVEL_W-1:0]       i_pin_levels,
    // result items
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [lmks_pkg::PIN_W-1:0]         o_drive_line,
    output logic                               o_drive_enable,
    output logic                               o_key_valid,
    output logic [lmks_pkg::KEY_W-1:0]         o_key_number,
    output logic [lmks_pkg::CHAR_W-1:0]        o_key_char,
    output logic                               o_learning,
    output logic [lmks_pkg::KEY_W-1:0]         o_prompt_key,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [1:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import lmks_pkg::*;

    // configuration
    logic [PIN_W-1:0]   r_pin_count;

    // input register
    logic               r_in_valid;
    logic               r_in_op;
    logic [LEVEL_W-1:0] r_in_levels;

    // result register
    logic               r_out_valid;
    t_result            r_out;

    logic               out_free;
    logic               step;
    logic               in_accept;

    t_tbl_req           tbl_req;
    t_entry             rd_entry;
    t_entry             cur_entry;
    t_result            step_result;

    // ---- APB: one register, every address in the word maps to it ----
    assign pready = 1'b1;
    assign prdata = {{(32 - PIN_W){1'b0}}, r_pin_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_count <= PIN_W'(7);
        end else if (psel && penable && pwrite && pready && (paddr[1:0] <= 2'd3)) begin
            r_pin_count <= pwdata[PIN_W-1:0];
        end
    end

    // ---- two-stage flow control ----
    assign out_free  = !r_out_valid || !i_stall;
    assign step      = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op     <= i_op;
            r_in_levels <= i_pin_levels;
        end
        if (step) begin
            r_out <= step_result;
        end
    end

    lmks_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_op         (r_in_op),
        .i_pin_levels (r_in_levels),
        .i_pin_count  (r_pin_count),
        .i_cur_entry  (cur_entry),
        .i_rd_entry   (rd_entry),
        .o_req        (tbl_req),
        .o_result     (step_result)
    );

    lmks_pair_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_req       (tbl_req),
        .o_rd_entry  (rd_entry),
        .o_cur_entry (cur_entry)
    );

    assign o_valid        = r_out_valid;
    assign o_drive_line   = r_out.drive_line;
    assign o_drive_enable = r_out.drive_enable;
    assign o_key_valid    = r_out.key_valid;
    assign o_key_number   = r_out.key_number;
    assign o_key_char     = r_out.key_char;
    assign o_learning     = r_out.learning;
    assign o_prompt_key   = r_out.prompt_key;

`ifndef ASSERT_OFF
    // a key is only reported from scanning
    a_report_not_learning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_valid) |-> !o_learning)
        else $error("key reported while learning");

    // reported position lies inside the layout
    a_key_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_valid) |-> (o_key_number <= KEY_LAST))
        else $error("key number out of range");

    // a learn start always yields a learning result at position zero
    a_learn_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_op) |=> (o_valid && o_learning && (o_prompt_key == '0)))
        else $error("learn start not seen at output");

    // unused drive line is zero
    a_drive_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_drive_enable) |-> (o_drive_line == '0))
        else $error("drive line set while not driving");
`endif

endmodule
